// ----- hw/rtl/rgb_to_hsl_converter_macros.svh -----
// ----------------------------------------------------------------------------
// rgb to hsl converter assertion macros
// shared concurrent assertion forms used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RHC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhc_pkg
// widths, constants and shared types of the rgb to hsl converter
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

  localparam int COMP_W  = 8;
  localparam int HUE_W   = 15;
  localparam int SAT_W   = 15;
  localparam int LIGHT_W = 15;

  localparam int IN_DATA_W  = ((3 * COMP_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((HUE_W + SAT_W + LIGHT_W + 7) / 8) * 8;

  // divider lanes: hue fraction and saturation
  localparam int NUM_LANES = 2;
  localparam int LANE_HUE  = 0;
  localparam int LANE_SAT  = 1;
  localparam int NUM_W     = 23;
  localparam int DEN_W     = COMP_W;
  localparam int QUO_W     = 15;
  localparam int DIV_STEP_BITS = 3;

  localparam int SUM_W = COMP_W + 1;

  // sum thresholds for the saturation denominator
  localparam logic [SUM_W-1:0] HALF_SUM = 9'd255;
  localparam logic [SUM_W-1:0] FULL_SUM = 9'd510;

  localparam logic [NUM_W-1:0] HUE_SIXTH  = 23'd3840;
  localparam logic [NUM_W-1:0] FULL_SCALE = 23'd25600;
  localparam logic [HUE_W-1:0] HUE_TURN   = 15'd23040;
  localparam logic [HUE_W-1:0] HUE_THIRD  = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_2THIRD = 15'd15360;

  // floor(2560*sum/51) as sum * round_up(2560 * 2^27 / 51) >> 27
  localparam int LIGHT_SHIFT  = 27;
  localparam int LIGHT_MULT_W = 33;
  localparam int LIGHT_PROD_W = SUM_W + LIGHT_MULT_W;
  localparam logic [LIGHT_MULT_W-1:0] LIGHT_MULT = 33'd6737203602;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0] den_t;
  typedef logic [QUO_W-1:0] quo_t;

  typedef enum logic [1:0] {
    SECTOR_RED   = 2'd0,
    SECTOR_GREEN = 2'd1,
    SECTOR_BLUE  = 2'd2
  } hue_sector_e;

  // per-pixel data that rides alongside the divider
  typedef struct packed {
    logic                grey;
    hue_sector_e         sector;
    logic                neg;
    logic [LIGHT_W-1:0]  light;
  } side_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rhc_prep.sv -----
// ----------------------------------------------------------------------------
// rhc_prep
// two-stage front end: extremes and sector, then numerators and lightness
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_prep (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    in_valid_i,
  output logic                                         in_ready_o,
  input  wire logic [rhc_pkg::COMP_W-1:0]              red_i,
  input  wire logic [rhc_pkg::COMP_W-1:0]              green_i,
  input  wire logic [rhc_pkg::COMP_W-1:0]              blue_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output rhc_pkg::num_t [rhc_pkg::NUM_LANES-1:0]       num_o,
  output rhc_pkg::den_t [rhc_pkg::NUM_LANES-1:0]       den_o,
  output rhc_pkg::side_t                               side_o
);
  import rhc_pkg::*;

  // stage 1 registers
  logic               s1_valid_q;
  logic [COMP_W-1:0]  s1_absdiff_q, s1_absdiff_d;
  logic               s1_neg_q, s1_neg_d;
  hue_sector_e        s1_sector_q, s1_sector_d;
  logic [COMP_W-1:0]  s1_delta_q, s1_delta_d;
  den_t               s1_den_q, s1_den_d;
  logic [SUM_W-1:0]   s1_sum_q, s1_sum_d;

  // stage 2 registers
  logic                          s2_valid_q;
  num_t [NUM_LANES-1:0]          s2_num_q, s2_num_d;
  den_t [NUM_LANES-1:0]          s2_den_q, s2_den_d;
  side_t                         s2_side_q, s2_side_d;

  logic adv1, adv2;

  logic [COMP_W-1:0]       mx, mn;
  logic signed [COMP_W:0]  diff;
  logic [LIGHT_PROD_W-1:0] light_prod;

  assign adv2       = !s2_valid_q || out_ready_i;
  assign adv1       = !s1_valid_q || adv2;
  assign in_ready_o = adv1;

  // max with red over green over blue on ties
  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      s1_sector_d = SECTOR_RED;
      mx          = red_i;
      diff        = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i >= blue_i) begin
      s1_sector_d = SECTOR_GREEN;
      mx          = green_i;
      diff        = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      s1_sector_d = SECTOR_BLUE;
      mx          = blue_i;
      diff        = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
    if (red_i <= green_i) begin
      mn = (red_i <= blue_i) ? red_i : blue_i;
    end else begin
      mn = (green_i <= blue_i) ? green_i : blue_i;
    end
    s1_neg_d     = diff[COMP_W];
    s1_absdiff_d = diff[COMP_W] ? COMP_W'(-diff) : diff[COMP_W-1:0];
    s1_delta_d   = mx - mn;
    s1_sum_d     = {1'b0, mx} + {1'b0, mn};
    if (s1_sum_d < HALF_SUM) begin
      s1_den_d = s1_sum_d[DEN_W-1:0];
    end else begin
      s1_den_d = DEN_W'(FULL_SUM - s1_sum_d);
    end
  end

  always_comb begin
    light_prod                = LIGHT_PROD_W'(s1_sum_q) * LIGHT_PROD_W'(LIGHT_MULT);
    s2_num_d[LANE_HUE]        = NUM_W'(s1_absdiff_q) * HUE_SIXTH;
    s2_num_d[LANE_SAT]        = NUM_W'(s1_delta_q) * FULL_SCALE;
    s2_den_d[LANE_HUE]        = s1_delta_q;
    s2_den_d[LANE_SAT]        = s1_den_q;
    s2_side_d.grey            = (s1_delta_q == '0);
    s2_side_d.sector          = s1_sector_q;
    s2_side_d.neg             = s1_neg_q;
    s2_side_d.light           = light_prod[LIGHT_SHIFT +: LIGHT_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv2) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_absdiff_q <= s1_absdiff_d;
      s1_neg_q     <= s1_neg_d;
      s1_sector_q  <= s1_sector_d;
      s1_delta_q   <= s1_delta_d;
      s1_den_q     <= s1_den_d;
      s1_sum_q     <= s1_sum_d;
    end
    if (adv2) begin
      s2_num_q  <= s2_num_d;
      s2_den_q  <= s2_den_d;
      s2_side_q <= s2_side_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign num_o       = s2_num_q;
  assign den_o       = s2_den_q;
  assign side_o      = s2_side_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rhc_div.sv -----
// ----------------------------------------------------------------------------
// rhc_div
// pipelined restoring divider, several lanes, STEP_BITS quotient bits a stage
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div #(
  parameter int LANES     = 2,
  parameter int NUM_W     = 23,
  parameter int DEN_W     = 8,
  parameter int QUO_W     = 15,
  parameter int STEP_BITS = 3,
  parameter int SIDE_W    = 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [LANES-1:0][NUM_W-1:0]  num_i,
  input  wire logic [LANES-1:0][DEN_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0]            side_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [LANES-1:0][QUO_W-1:0]       quo_o,
  output logic [LANES-1:0][DEN_W-1:0]       rem_o,
  output logic [SIDE_W-1:0]                 side_o
);

  localparam int STAGES = (QUO_W + STEP_BITS - 1) / STEP_BITS;

  // quotient fits QUO_W bits, so the top numerator bits start below the divisor
  logic [STAGES-1:0]                        valid_q;
  logic [STAGES-1:0][LANES-1:0][DEN_W-1:0]  rem_q, rem_d;
  logic [STAGES-1:0][LANES-1:0][QUO_W-1:0]  nq_q, nq_d;
  logic [STAGES-1:0][LANES-1:0][DEN_W-1:0]  den_q;
  logic [STAGES-1:0][SIDE_W-1:0]            side_q;
  logic [STAGES-1:0]                        adv;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic                         prev_valid;
    logic [LANES-1:0][DEN_W-1:0]  prev_rem;
    logic [LANES-1:0][QUO_W-1:0]  prev_nq;
    logic [LANES-1:0][DEN_W-1:0]  prev_den;
    logic [SIDE_W-1:0]            prev_side;

    if (s == 0) begin : g_first
      assign prev_valid = in_valid_i;
      assign prev_den   = den_i;
      assign prev_side  = side_i;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign prev_rem[l] = DEN_W'(num_i[l] >> QUO_W);
        assign prev_nq[l]  = num_i[l][QUO_W-1:0];
      end
    end else begin : g_rest
      assign prev_valid = valid_q[s-1];
      assign prev_rem   = rem_q[s-1];
      assign prev_nq    = nq_q[s-1];
      assign prev_den   = den_q[s-1];
      assign prev_side  = side_q[s-1];
    end

    if (s == STAGES - 1) begin : g_last
      assign adv[s] = !valid_q[s] || out_ready_i;
    end else begin : g_mid
      assign adv[s] = !valid_q[s] || adv[s+1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_calc
      always_comb begin : step
        logic [DEN_W:0]   trial;
        logic [DEN_W-1:0] r;
        logic [QUO_W-1:0] nq;
        r     = prev_rem[l];
        nq    = prev_nq[l];
        trial = '0;
        for (int j = 0; j < STEP_BITS; j++) begin
          if (s * STEP_BITS + j < QUO_W) begin
            trial = {r, nq[QUO_W-1]};
            nq    = {nq[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, prev_den[l]}) begin
              trial = trial - {1'b0, prev_den[l]};
              nq[0] = 1'b1;
            end
            r = trial[DEN_W-1:0];
          end
        end
        rem_d[s][l] = r;
        nq_d[s][l]  = nq;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (adv[s]) begin
        valid_q[s] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[s]) begin
        rem_q[s]  <= rem_d[s];
        nq_q[s]   <= nq_d[s];
        den_q[s]  <= prev_den;
        side_q[s] <= prev_side;
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[STAGES-1];
  assign quo_o       = nq_q[STAGES-1];
  assign rem_o       = rem_q[STAGES-1];
  assign side_o      = side_q[STAGES-1];

endmodule

`default_nettype wire

// ----- hw/rtl/rhc_post.sv -----
// ----------------------------------------------------------------------------
// rhc_post
// hue assembly with wrap, grey override and output register
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_post (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire rhc_pkg::quo_t [rhc_pkg::NUM_LANES-1:0] quo_i,
  input  wire rhc_pkg::den_t [rhc_pkg::NUM_LANES-1:0] rem_i,
  input  wire rhc_pkg::side_t                        side_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [rhc_pkg::HUE_W-1:0]                  hue_o,
  output logic [rhc_pkg::SAT_W-1:0]                  sat_o,
  output logic [rhc_pkg::LIGHT_W-1:0]                light_o,
  output logic                                       grey_o
);
  import rhc_pkg::*;

  logic                valid_q;
  logic [HUE_W-1:0]    hue_q, hue_d;
  logic [SAT_W-1:0]    sat_q, sat_d;
  logic [LIGHT_W-1:0]  light_q;
  logic                grey_q;
  logic                adv;

  logic [HUE_W-1:0]    base;
  logic [HUE_W:0]      hue_sum;
  logic                frac_rem;

  assign adv        = !valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    case (side_i.sector)
      SECTOR_RED:   base = side_i.neg ? HUE_TURN : '0;
      SECTOR_GREEN: base = HUE_THIRD;
      SECTOR_BLUE:  base = HUE_2THIRD;
      default:      base = '0;
    endcase
    // negative fraction rounds down: subtract one more when there is a remainder
    frac_rem = |rem_i[LANE_HUE];
    if (side_i.neg) begin
      hue_sum = {1'b0, base} - (HUE_W+1)'(quo_i[LANE_HUE]) - (HUE_W+1)'(frac_rem);
    end else begin
      hue_sum = {1'b0, base} + (HUE_W+1)'(quo_i[LANE_HUE]);
    end
    if (side_i.grey) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      hue_d = hue_sum[HUE_W-1:0];
      sat_d = SAT_W'(quo_i[LANE_SAT]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      light_q <= side_i.light;
      grey_q  <= side_i.grey;
    end
  end

  assign out_valid_o = valid_q;
  assign hue_o       = hue_q;
  assign sat_o       = sat_q;
  assign light_o     = light_q;
  assign grey_o      = grey_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_to_hsl_converter.sv -----
// the result passes the front-end stages, the divider stages and the output register
// throughput: one pixel per clock while the output is not stalled; every stage holds its own valid bit
// the divider stages, each resolving DIV_STEP_BITS quotient bits, set the depth
// a stalled output stalls only the stages behind it, bubbles are squeezed out
// reset clears the valid bits only, not the data register state
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// streaming rgb pixel to hue, saturation and lightness in fixed point
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_to_hsl_converter_macros.svh"

module rgb_to_hsl_converter #(
  parameter int DIV_STEP_BITS = rhc_pkg::DIV_STEP_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input pixel request
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // red [7:0], green [15:8], blue [23:16]
  input  wire logic [rhc_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // result request
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // hue [14:0], saturation [29:15], lightness [44:30], zero [47:45]
  output logic [rhc_pkg::OUT_DATA_W-1:0]         m_axis_tdata_o,
  // is_grey [0]
  output logic                                   m_axis_tuser_o
);
  import rhc_pkg::*;

  localparam int SIDE_W = $bits(side_t);

  // front end to divider
  logic                     prep_valid, prep_ready;
  num_t [NUM_LANES-1:0]     prep_num;
  den_t [NUM_LANES-1:0]     prep_den;
  side_t                    prep_side;

  // divider to back end
  logic                     div_valid, div_ready;
  quo_t [NUM_LANES-1:0]     div_quo;
  den_t [NUM_LANES-1:0]     div_rem;
  logic [SIDE_W-1:0]        div_side;
  side_t                    post_side;

  logic [HUE_W-1:0]         hue;
  logic [SAT_W-1:0]         sat;
  logic [LIGHT_W-1:0]       light;
  logic                     grey;

  // max/min, sector, signed difference; then the two dividends and lightness
  rhc_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .red_i       (s_axis_tdata_i[COMP_W-1:0]),
    .green_i     (s_axis_tdata_i[2*COMP_W-1:COMP_W]),
    .blue_i      (s_axis_tdata_i[3*COMP_W-1:2*COMP_W]),
    .out_valid_o (prep_valid),
    .out_ready_i (prep_ready),
    .num_o       (prep_num),
    .den_o       (prep_den),
    .side_o      (prep_side)
  );

  // lane 0: 3840*|diff| / delta, lane 1: 25600*delta / denominator
  rhc_div #(
    .LANES     (NUM_LANES),
    .NUM_W     (NUM_W),
    .DEN_W     (DEN_W),
    .QUO_W     (QUO_W),
    .STEP_BITS (DIV_STEP_BITS),
    .SIDE_W    (SIDE_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prep_valid),
    .in_ready_o  (prep_ready),
    .num_i       (prep_num),
    .den_i       (prep_den),
    .side_i      (prep_side),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .quo_o       (div_quo),
    .rem_o       (div_rem),
    .side_o      (div_side)
  );

  assign post_side = side_t'(div_side);

  // sector offset, floor of a negative fraction, wrap into one turn
  rhc_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .quo_i       (div_quo),
    .rem_i       (div_rem),
    .side_i      (post_side),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .hue_o       (hue),
    .sat_o       (sat),
    .light_o     (light),
    .grey_o      (grey)
  );

  // pack result, zero fill to whole bytes
  assign m_axis_tdata_o = {(OUT_DATA_W - HUE_W - SAT_W - LIGHT_W)'(0), light, sat, hue};
  assign m_axis_tuser_o = grey;

  // grey pixels carry no hue and no saturation
  `RHC_ASSERT_IMPLY(a_grey_zero, clk_i, rst_ni, m_axis_tvalid_o && grey,
    hue == '0 && sat == '0, "grey result with nonzero hue or saturation")

  // hue stays inside one turn, the others inside full scale
  `RHC_ASSERT_IMPLY(a_range, clk_i, rst_ni, m_axis_tvalid_o,
    hue < HUE_TURN && sat <= 15'd25600 && light <= 15'd25600,
    "result field out of range")

  // input side only backs up when every stage is full and the output is stalled
  `RHC_ASSERT_IMPLY(a_full_stall, clk_i, rst_ni, !s_axis_tready_o,
    m_axis_tvalid_o && !m_axis_tready_i, "input stalled while pipeline has room")

  // a full pipeline still has a result to offer on the next cycle
  `RHC_ASSERT_NEXT(a_full_holds, clk_i, rst_ni, !s_axis_tready_o,
    m_axis_tvalid_o, "full pipeline lost its result")

endmodule

`default_nettype wire
